@@ hw/rtl/fst_pkg.sv @@
package fst_pkg;

  // Fixed point and lighting constants
  localparam int FRACBITS       = 16;
  localparam int FRACUNIT       = 65536;
  localparam int MAX_ROWS       = 1024;
  localparam int MAX_COLUMNS    = 2048;
  localparam int LIGHT_Z_SHIFT  = 20;
  localparam int LIGHT_Z_LEVELS = 128;
  localparam int LIGHTZSHIFT    = LIGHT_Z_SHIFT;
  localparam int MAXLIGHTZ      = LIGHT_Z_LEVELS;

  // Field widths
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int FX_W    = 32;
  localparam int IN_W    = 31;
  localparam int TRIG_W  = 18;
  localparam int LIGHT_W = $clog2(LIGHT_Z_LEVELS);
  localparam int CFG_IDX_W = 3;

  // Row offset from the horizon, in unsigned 10.16
  localparam int DY_W = ROW_W + FRACBITS;

  // Divider geometry: magnitude shifted left by FRACBITS, a few bits a stage
  localparam int DIVIDEND_W = FX_W + FRACBITS;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = DIVIDEND_W / DIV_BITS;
  localparam int DIV_LAT    = DIV_STAGES + 1;
  localparam int SIDE_DELAY = DIV_LAT - 1;
  localparam int PIPE_LAT   = 6 + SIDE_DELAY;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_ROW   = 3'd0,
    REG_CENTER_COL   = 3'd1,
    REG_VIEW_X       = 3'd2,
    REG_VIEW_Y       = 3'd3,
    REG_VIEW_SIN     = 3'd4,
    REG_VIEW_COS     = 3'd5,
    REG_DETAIL_SHIFT = 3'd6,
    REG_FIXED_CMAP   = 3'd7
  } reg_idx_t;

  // Fields that wait beside the dividers
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   x_start;
    logic [COL_W-1:0]   x_end;
    logic [FX_W-1:0]    dx;
    logic [FX_W-1:0]    mcos;
    logic [FX_W-1:0]    msin;
    logic [LIGHT_W-1:0] light;
    logic               fixed;
  } side_t;

endpackage

@@ hw/rtl/fst_div.sv @@
module fst_div (
  input  logic                     clk,
  input  logic [fst_pkg::FX_W-1:0] mag,
  input  logic [fst_pkg::DY_W-1:0] den,
  input  logic                     neg,
  input  logic                     sat,
  output logic [fst_pkg::FX_W-1:0] quo
);
  import fst_pkg::*;

  logic [DY_W-1:0]       rem_r [DIV_STAGES];
  logic [FX_W-1:0]       quo_r [DIV_STAGES];
  logic [DIVIDEND_W-1:0] num_r [DIV_STAGES];
  logic [DY_W-1:0]       den_r [DIV_STAGES];
  logic                  neg_r [DIV_STAGES];
  logic                  sat_r [DIV_STAGES];

  logic [DY_W-1:0]       rem_nxt [DIV_STAGES];
  logic [FX_W-1:0]       quo_nxt [DIV_STAGES];
  logic [DIVIDEND_W-1:0] num_nxt [DIV_STAGES];

  logic [FX_W-1:0] quo_r_out;

  // Restoring division, DIV_BITS quotient bits per stage
  always_comb begin
    logic [DY_W-1:0]       r;
    logic [FX_W-1:0]       q;
    logic [DIVIDEND_W-1:0] n;
    logic [DY_W-1:0]       d;
    logic [DY_W:0]         t;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        r = '0;
        q = '0;
        n = {mag, {FRACBITS{1'b0}}};
        d = den;
      end else begin
        r = rem_r[s-1];
        q = quo_r[s-1];
        n = num_r[s-1];
        d = den_r[s-1];
      end
      for (int b = 0; b < DIV_BITS; b++) begin
        t = {r, n[DIVIDEND_W-1]};
        n = {n[DIVIDEND_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t = t - {1'b0, d};
          q = {q[FX_W-2:0], 1'b1};
        end else begin
          q = {q[FX_W-2:0], 1'b0};
        end
        r = t[DY_W-1:0];
      end
      rem_nxt[s] = r;
      quo_nxt[s] = q;
      num_nxt[s] = n;
    end
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_r[s] <= rem_nxt[s];
      quo_r[s] <= quo_nxt[s];
      num_r[s] <= num_nxt[s];
      if (s == 0) begin
        den_r[s] <= den;
        neg_r[s] <= neg;
        sat_r[s] <= sat;
      end else begin
        den_r[s] <= den_r[s-1];
        neg_r[s] <= neg_r[s-1];
        sat_r[s] <= sat_r[s-1];
      end
    end
  end

  // Apply sign or saturate
  always_ff @(posedge clk) begin
    if (sat_r[DIV_STAGES-1]) begin
      quo_r_out <= neg_r[DIV_STAGES-1] ? {1'b1, {(FX_W-1){1'b0}}} : {1'b0, {(FX_W-1){1'b1}}};
    end else if (neg_r[DIV_STAGES-1]) begin
      quo_r_out <= ~quo_r[DIV_STAGES-1] + 1'b1;
    end else begin
      quo_r_out <= quo_r[DIV_STAGES-1];
    end
  end

  assign quo = quo_r_out;

endmodule

@@ hw/rtl/floor_span_texture_setup.sv @@
// Floor span texture setup, fully pipelined.
// Each item passes the input stage, multiply stages and the 12-stage dividers
// (4 quotient bits a stage), then the sum stages, before out_strobe.
// Throughput: one item per cycle; busy stays low, results cannot be held off.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
module floor_span_texture_setup (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fst_pkg::ROW_W-1:0]     in_row,
  input  logic [fst_pkg::COL_W-1:0]     in_x_start,
  input  logic [fst_pkg::COL_W-1:0]     in_x_end,
  input  logic [fst_pkg::IN_W-1:0]      in_plane_height,
  input  logic [fst_pkg::IN_W-1:0]      in_row_slope,
  input  logic                          cfg_we,
  input  logic [fst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fst_pkg::FX_W-1:0]      cfg_data,
  output logic                          out_strobe,
  output logic [fst_pkg::ROW_W-1:0]     out_span_row,
  output logic [fst_pkg::COL_W-1:0]     out_span_x_start,
  output logic [fst_pkg::COL_W-1:0]     out_span_x_end,
  output logic signed [fst_pkg::FX_W-1:0] out_u_start,
  output logic signed [fst_pkg::FX_W-1:0] out_v_start,
  output logic signed [fst_pkg::FX_W-1:0] out_u_step,
  output logic signed [fst_pkg::FX_W-1:0] out_v_step,
  output logic [fst_pkg::LIGHT_W-1:0]   out_light_index,
  output logic                          out_fixed_light
);
  import fst_pkg::*;

  localparam int PW = TRIG_W + FX_W;

  // Configuration registers
  logic [ROW_W-1:0]         center_row_r;
  logic [COL_W-1:0]         center_col_r;
  logic [FX_W-1:0]          view_x_r;
  logic [FX_W-1:0]          view_y_r;
  logic signed [TRIG_W-1:0] view_sin_r;
  logic signed [TRIG_W-1:0] view_cos_r;
  logic                     detail_r;
  logic                     fixed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_row_r <= ROW_W'(100);
      center_col_r <= COL_W'(160);
      view_x_r     <= '0;
      view_y_r     <= '0;
      view_sin_r   <= '0;
      view_cos_r   <= TRIG_W'(FRACUNIT);
      detail_r     <= 1'b0;
      fixed_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CENTER_ROW:   center_row_r <= cfg_data[ROW_W-1:0];
        REG_CENTER_COL:   center_col_r <= cfg_data[COL_W-1:0];
        REG_VIEW_X:       view_x_r     <= cfg_data;
        REG_VIEW_Y:       view_y_r     <= cfg_data;
        REG_VIEW_SIN:     view_sin_r   <= cfg_data[TRIG_W-1:0];
        REG_VIEW_COS:     view_cos_r   <= cfg_data[TRIG_W-1:0];
        REG_DETAIL_SHIFT: detail_r     <= cfg_data[0];
        REG_FIXED_CMAP:   fixed_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: capture item, drop horizon rows
  logic             s1_vld_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_xs_r, s1_xe_r;
  logic [IN_W-1:0]  s1_h_r, s1_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && (in_row != center_row_r);
  end

  always_ff @(posedge clk) begin
    s1_row_r <= in_row;
    s1_xs_r  <= in_x_start;
    s1_xe_r  <= in_x_end;
    s1_h_r   <= in_plane_height;
    s1_s_r   <= in_row_slope;
  end

  // Stage A: row offset, column offset and height products
  logic                  a_vld_r;
  logic [ROW_W-1:0]      a_row_r;
  logic [COL_W-1:0]      a_xs_r, a_xe_r;
  logic [DY_W-1:0]       a_dy_r;
  logic [FX_W-1:0]       a_dx_r;
  logic [2*IN_W-1:0]     a_hs_r;
  logic signed [PW-1:0]  a_psin_r, a_pcos_r;
  logic [ROW_W-1:0]      d_rows;
  logic [DY_W-1:0]       dy_nxt;

  always_comb begin
    if (s1_row_r < center_row_r) begin
      d_rows = center_row_r - s1_row_r;
      dy_nxt = {d_rows, {FRACBITS{1'b0}}} - DY_W'(FRACUNIT / 2);
    end else begin
      d_rows = s1_row_r - center_row_r;
      dy_nxt = {d_rows, {FRACBITS{1'b0}}} + DY_W'(FRACUNIT / 2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    a_row_r  <= s1_row_r;
    a_xs_r   <= s1_xs_r;
    a_xe_r   <= s1_xe_r;
    a_dy_r   <= dy_nxt;
    a_dx_r   <= FX_W'(s1_xs_r) - FX_W'(center_col_r);
    a_hs_r   <= {{IN_W{1'b0}}, s1_h_r} * {{IN_W{1'b0}}, s1_s_r};
    a_psin_r <= PW'(view_sin_r) * PW'(signed'({1'b0, s1_h_r}));
    a_pcos_r <= PW'(view_cos_r) * PW'(signed'({1'b0, s1_h_r}));
  end

  // Stage B: distance, dividend magnitudes and saturation checks
  logic             b_vld_r;
  logic [ROW_W-1:0] b_row_r;
  logic [COL_W-1:0] b_xs_r, b_xe_r;
  logic [FX_W-1:0]  b_dx_r, b_dist_r;
  logic [DY_W-1:0]  b_dy_r;
  logic [FX_W-1:0]  b_mag_s_r, b_mag_c_r;
  logic             b_neg_s_r, b_neg_c_r, b_sat_s_r, b_sat_c_r;
  logic [FX_W-1:0]  asin, acos, mag_s, mag_c;

  always_comb begin
    asin  = a_psin_r[FX_W+FRACBITS-1:FRACBITS];
    acos  = a_pcos_r[FX_W+FRACBITS-1:FRACBITS];
    mag_s = asin[FX_W-1] ? ~asin + 1'b1 : asin;
    mag_c = acos[FX_W-1] ? ~acos + 1'b1 : acos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else        b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    b_row_r   <= a_row_r;
    b_xs_r    <= a_xs_r;
    b_xe_r    <= a_xe_r;
    b_dx_r    <= a_dx_r;
    b_dy_r    <= a_dy_r;
    b_dist_r  <= a_hs_r[FX_W+FRACBITS-1:FRACBITS];
    b_mag_s_r <= mag_s;
    b_mag_c_r <= mag_c;
    b_neg_s_r <= asin[FX_W-1];
    b_neg_c_r <= acos[FX_W-1];
    b_sat_s_r <= FX_W'(mag_s >> 14) >= FX_W'(a_dy_r);
    b_sat_c_r <= FX_W'(mag_c >> 14) >= FX_W'(a_dy_r);
  end

  // Step dividers
  logic [FX_W-1:0] qu, qv;

  fst_div u_div_u (
    .clk (clk),
    .mag (b_mag_s_r),
    .den (b_dy_r),
    .neg (b_neg_s_r),
    .sat (b_sat_s_r),
    .quo (qu)
  );

  fst_div u_div_v (
    .clk (clk),
    .mag (b_mag_c_r),
    .den (b_dy_r),
    .neg (b_neg_c_r),
    .sat (b_sat_c_r),
    .quo (qv)
  );

  // Stage C: distance products and light index
  logic                 c_vld_r;
  side_t                c_side_r;
  logic signed [PW-1:0] pdcos, pdsin;
  logic [FX_W-1:0]      light_full;
  logic [LIGHT_W-1:0]   light_nxt;

  always_comb begin
    pdcos      = PW'(view_cos_r) * PW'(signed'(b_dist_r));
    pdsin      = PW'(view_sin_r) * PW'(signed'(b_dist_r));
    light_full = b_dist_r >> LIGHT_Z_SHIFT;
    if (fixed_r) begin
      light_nxt = '0;
    end else if (light_full >= FX_W'(LIGHT_Z_LEVELS)) begin
      light_nxt = LIGHT_W'(LIGHT_Z_LEVELS - 1);
    end else begin
      light_nxt = light_full[LIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else        c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    c_side_r.row     <= b_row_r;
    c_side_r.x_start <= b_xs_r;
    c_side_r.x_end   <= b_xe_r;
    c_side_r.dx      <= b_dx_r;
    c_side_r.mcos    <= pdcos[FX_W+FRACBITS-1:FRACBITS];
    c_side_r.msin    <= pdsin[FX_W+FRACBITS-1:FRACBITS];
    c_side_r.light   <= light_nxt;
    c_side_r.fixed   <= fixed_r;
  end

  // Hold side fields until the quotients arrive
  logic  ln_vld_r  [SIDE_DELAY];
  side_t ln_side_r [SIDE_DELAY];

  always_ff @(posedge clk) begin
    for (int i = 0; i < SIDE_DELAY; i++) begin
      if (!rst_n)      ln_vld_r[i] <= 1'b0;
      else if (i == 0) ln_vld_r[i] <= c_vld_r;
      else             ln_vld_r[i] <= ln_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SIDE_DELAY; i++) begin
      if (i == 0) ln_side_r[i] <= c_side_r;
      else        ln_side_r[i] <= ln_side_r[i-1];
    end
  end

  // Stage D: shift steps, column offset products
  logic            d_vld_r;
  side_t           d_side_r;
  logic [FX_W-1:0] d_us_r, d_vs_r, d_pu_r, d_pv_r;
  logic [FX_W-1:0] us_nxt, vs_nxt;

  always_comb begin
    us_nxt = qu << detail_r;
    vs_nxt = qv << detail_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else        d_vld_r <= ln_vld_r[SIDE_DELAY-1];
  end

  always_ff @(posedge clk) begin
    d_side_r <= ln_side_r[SIDE_DELAY-1];
    d_us_r   <= us_nxt;
    d_vs_r   <= vs_nxt;
    d_pu_r   <= ln_side_r[SIDE_DELAY-1].dx * us_nxt;
    d_pv_r   <= ln_side_r[SIDE_DELAY-1].dx * vs_nxt;
  end

  // Stage E: final sums into the output registers
  logic            out_vld_r;
  side_t           out_side_r;
  logic [FX_W-1:0] out_u_r, out_v_r, out_us_r, out_vs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= d_vld_r;
  end

  always_ff @(posedge clk) begin
    out_side_r <= d_side_r;
    out_us_r   <= d_us_r;
    out_vs_r   <= d_vs_r;
    out_u_r    <= view_x_r + d_side_r.mcos + d_pu_r;
    out_v_r    <= (FX_W'(0) - view_y_r) - d_side_r.msin + d_pv_r;
  end

  assign out_strobe       = out_vld_r;
  assign out_span_row     = out_side_r.row;
  assign out_span_x_start = out_side_r.x_start;
  assign out_span_x_end   = out_side_r.x_end;
  assign out_u_start      = out_u_r;
  assign out_v_start      = out_v_r;
  assign out_u_step       = out_us_r;
  assign out_v_step       = out_vs_r;
  assign out_light_index  = out_side_r.light;
  assign out_fixed_light  = out_side_r.fixed;

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT))
    else $error("result without an item accepted PIPE_LAT cycles before");

  a_fixed_light: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_fixed_light) |-> (out_light_index == '0))
    else $error("fixed colormap with nonzero light index");

  a_reset_flush: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_strobe)
    else $error("result strobe right after reset");

endmodule
